>>> hw/rtl/msf_pkg.sv
`timescale 1ns / 1ps

package msf_pkg;

  // Payload widths of the two channels
  localparam int unsigned MSG_W   = 24;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned HELD_W  = 16;

  // Item kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Which part of the popped message goes out on the transmitter
  typedef enum logic [1:0] {
    BSEL_NONE = 2'd0,
    BSEL_HIGH = 2'd1,
    BSEL_MID  = 2'd2,
    BSEL_LOW  = 2'd3
  } byte_sel_t;

  // Per-beat result from the sequencer, held in the output register
  typedef struct packed {
    logic               tx_valid;
    byte_sel_t          byte_sel;
    logic               rx_take;
    logic               setup_strobe;
    logic [STATE_W-1:0] sender_state;
    logic [COUNT_W-1:0] queue_count;
    logic               push_dropped;
  } step_res_t;

endpackage

>>> hw/rtl/msf_if.sv
`timescale 1ns / 1ps

// Input channel: push or tick beats
interface msf_in_if;
  import msf_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [MSG_W-1:0] message;
  logic             rx_has_byte;
  logic             tx_empty;

  modport source (output valid, kind, message, rx_has_byte, tx_empty, input ready);
  modport sink   (input valid, kind, message, rx_has_byte, tx_empty, output ready);
endinterface

// Result channel: one beat per input beat
interface msf_out_if;
  import msf_pkg::*;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [BYTE_W-1:0]  tx_byte;
  logic               rx_take;
  logic               setup_strobe;
  logic [STATE_W-1:0] sender_state;
  logic [COUNT_W-1:0] queue_count;
  logic               push_dropped;

  modport source (output valid, tx_valid, tx_byte, rx_take, setup_strobe, sender_state,
                  queue_count, push_dropped, input ready);
  modport sink   (input valid, tx_valid, tx_byte, rx_take, setup_strobe, sender_state,
                  queue_count, push_dropped, output ready);
endinterface

>>> hw/rtl/uart_message_fifo_byte_sender_core.sv
`timescale 1ns / 1ps

// Message FIFO with a request-driven byte sender. Push beats (kind 0) append a 24-bit
// message to a ring of QUEUE_DEPTH entries, or flag push_dropped when it is full; tick
// beats (kind 1) step the sender through boot, init and ready, then send each popped
// message high byte first, one byte per request byte and free transmitter. Every input
// beat yields exactly one result beat. The block takes one beat per clock: the ring sits
// in a single memory with one write port (pushes) and one registered read port (pops),
// and a push and a pop never fall on the same beat, so no beat waits for the other. The
// result is registered, so a beat is taken whenever the result slot is empty or being
// taken on the same edge. The message store needs no clearing after reset.
module uart_message_fifo_byte_sender_core
  import msf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  msf_in_if.sink   in_ch,
  msf_out_if.source out_ch
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [MSG_W-1:0] rd_data;
  step_res_t        res, res_r;
  logic             out_valid_r;

  // Take a beat when the result slot is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  msf_seq #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .kind        (in_ch.kind),
    .rx_has_byte (in_ch.rx_has_byte),
    .tx_empty    (in_ch.tx_empty),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .res         (res)
  );

  msf_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.message),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // The read register holds the last popped message; its low bytes serve send2/send3
  always_comb begin
    case (res_r.byte_sel)
      BSEL_HIGH: out_ch.tx_byte = rd_data[23:16];
      BSEL_MID:  out_ch.tx_byte = rd_data[15:8];
      BSEL_LOW:  out_ch.tx_byte = rd_data[7:0];
      default:   out_ch.tx_byte = '0;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tx_valid     = res_r.tx_valid;
  assign out_ch.rx_take      = res_r.rx_take;
  assign out_ch.setup_strobe = res_r.setup_strobe;
  assign out_ch.sender_state = res_r.sender_state;
  assign out_ch.queue_count  = res_r.queue_count;
  assign out_ch.push_dropped = res_r.push_dropped;

  // A byte source is chosen only for a beat that sends
  a_sel_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.byte_sel != BSEL_NONE) |-> res_r.tx_valid)
    else $error("byte source without a send");

  // A pop loads the result slot on the same edge
  a_pop_with_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> accept)
    else $error("memory read without a beat");

  // A dropped push never sends
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.push_dropped) |-> !res_r.tx_valid && !res_r.rx_take)
    else $error("dropped push with sender activity");

endmodule

>>> hw/rtl/msf_ram.sv
`timescale 1ns / 1ps

module msf_ram
  import msf_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [MSG_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [MSG_W-1:0] rd_data
);

  logic [MSG_W-1:0] mem [DEPTH];
  logic [MSG_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the word stays until the next pop
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/msf_seq.sv
`timescale 1ns / 1ps

module msf_seq
  import msf_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned CW    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             kind,
  input  logic             rx_has_byte,
  input  logic             tx_empty,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output step_res_t        res
);

  typedef enum logic [STATE_W-1:0] {
    ST_BOOT  = 4'd0,
    ST_INIT  = 4'd1,
    ST_READY = 4'd2,
    ST_WAIT1 = 4'd3,
    ST_SEND1 = 4'd4,
    ST_WAIT2 = 4'd5,
    ST_SEND2 = 4'd6,
    ST_WAIT3 = 4'd7,
    ST_SEND3 = 4'd8
  } state_t;

  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic      is_push, is_tick, dropped, take, pop_now;
  byte_sel_t bsel;

  assign is_push = step_en && (kind == KIND_PUSH);
  assign is_tick = step_en && (kind == KIND_TICK);

  // Sender transition for a tick
  always_comb begin
    state_nxt = state_r;
    take      = 1'b0;
    if (is_tick) begin
      unique case (state_r)
        ST_BOOT:  state_nxt = ST_INIT;
        ST_INIT:  state_nxt = ST_READY;
        ST_READY: begin
          if ((cnt_r != '0) && rx_has_byte) begin
            take      = 1'b1;
            state_nxt = ST_WAIT1;
          end
        end
        ST_WAIT1: state_nxt = tx_empty ? ST_SEND1 : ST_WAIT1;
        ST_SEND1: state_nxt = ST_WAIT2;
        ST_WAIT2: begin
          if (tx_empty && rx_has_byte) begin
            take      = 1'b1;
            state_nxt = ST_SEND2;
          end
        end
        ST_SEND2: state_nxt = ST_WAIT3;
        ST_WAIT3: begin
          if (tx_empty && rx_has_byte) begin
            take      = 1'b1;
            state_nxt = ST_SEND3;
          end
        end
        ST_SEND3: state_nxt = ST_READY;
        default:  state_nxt = ST_BOOT;
      endcase
    end
  end

  // Pop on entering send1; an empty ring sends a zero byte and stays put
  assign pop_now = is_tick && (state_nxt == ST_SEND1) && (state_r != ST_SEND1);
  assign rd_en   = pop_now && (cnt_r != '0);
  assign rd_addr = head_r;

  // Push into the ring unless full
  assign dropped = is_push && (cnt_r == FULL_C);
  assign wr_en   = is_push && !dropped;
  assign wr_addr = tail_r;

  // Pointer and count update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      tail_nxt = (tail_r == LAST_C) ? '0 : tail_r + AW'(1);
      cnt_nxt  = cnt_r + CW'(1);
    end
    if (rd_en) begin
      head_nxt = (head_r == LAST_C) ? '0 : head_r + AW'(1);
      cnt_nxt  = cnt_r - CW'(1);
    end
  end

  // Byte source for this beat
  always_comb begin
    bsel = BSEL_NONE;
    if (is_tick && (state_nxt != state_r || state_r == ST_SEND1)) begin
      unique case (state_nxt)
        ST_SEND1: bsel = (cnt_r != '0) ? BSEL_HIGH : BSEL_NONE;
        ST_SEND2: bsel = BSEL_MID;
        ST_SEND3: bsel = BSEL_LOW;
        default:  bsel = BSEL_NONE;
      endcase
    end
  end

  always_comb begin
    res.tx_valid     = is_tick && (state_nxt == ST_SEND1 || state_nxt == ST_SEND2 ||
                                   state_nxt == ST_SEND3);
    res.byte_sel     = bsel;
    res.rx_take      = take;
    res.setup_strobe = is_tick && (state_nxt == ST_INIT);
    res.sender_state = STATE_W'(state_nxt);
    res.queue_count  = COUNT_W'(cnt_nxt);
    res.push_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Ring occupancy never passes its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_C)
    else $error("message count beyond depth");

  // A pop only ever follows a wait1 tick
  a_pop_from_wait1: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == ST_WAIT1))
    else $error("pop outside wait1");

  // Pointers agree with the count when the ring is empty
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("empty ring with pointers apart");

  // A tick that takes a request byte moves the sender
  a_take_moves: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r != $past(state_r)))
    else $error("request byte taken without a state change");

endmodule

>>> verif/tb_uart_message_fifo_byte_sender_core.sv
`timescale 1ns / 1ps

module tb_uart_message_fifo_byte_sender_core;
  import msf_pkg::*;

  localparam int DEPTH          = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 10;

  // Sender state codes as seen on sender_state
  typedef enum logic [STATE_W-1:0] {
    SND_BOOT  = 4'd0,
    SND_INIT  = 4'd1,
    SND_READY = 4'd2,
    SND_WAIT1 = 4'd3,
    SND_SEND1 = 4'd4,
    SND_WAIT2 = 4'd5,
    SND_SEND2 = 4'd6,
    SND_WAIT3 = 4'd7,
    SND_SEND3 = 4'd8
  } sndr_state_t;

  // One result beat, field for field
  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               rx_take;
    logic               setup_strobe;
    logic [STATE_W-1:0] sender_state;
    logic [COUNT_W-1:0] queue_count;
    logic               push_dropped;
  } sender_obs_t;

  logic clk;
  logic rst_n;

  msf_in_if  in_bus ();
  msf_out_if out_bus ();

  uart_message_fifo_byte_sender_core #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Predicted block state
  logic [MSG_W-1:0]  msg_ring [DEPTH];
  int                ring_head;
  int                ring_tail;
  int                ring_count;
  logic [HELD_W-1:0] held_low;
  sndr_state_t       sndr_state;

  sender_obs_t pending_obs[$];

  int  mismatch_count;
  int  beats_in;
  int  beats_out;
  int  bytes_sent;
  int  pushes_dropped;
  int  idle_cycles;
  int  rx_hold_cycles;
  bit  idle_en;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next result of the block for one accepted input beat; updates the predicted state
  function automatic sender_obs_t predict_step(input logic k, input logic [MSG_W-1:0] m,
                                               input logic rx, input logic txe);
    sender_obs_t r;
    sndr_state_t nxt;
    logic [MSG_W-1:0] popped;
    r = '0;
    if (k == KIND_PUSH) begin
      if (ring_count >= DEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        msg_ring[ring_tail] = m;
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_count++;
      end
    end else begin
      case (sndr_state)
        SND_BOOT:  nxt = SND_INIT;
        SND_INIT:  nxt = SND_READY;
        SND_READY: begin
          if (ring_count != 0 && rx) begin
            r.rx_take = 1'b1;
            nxt = SND_WAIT1;
          end else begin
            nxt = SND_READY;
          end
        end
        SND_WAIT1: nxt = txe ? SND_SEND1 : SND_WAIT1;
        SND_SEND1: nxt = SND_WAIT2;
        SND_WAIT2: begin
          if (txe && rx) begin
            r.rx_take = 1'b1;
            nxt = SND_SEND2;
          end else begin
            nxt = SND_WAIT2;
          end
        end
        SND_SEND2: nxt = SND_WAIT3;
        SND_WAIT3: begin
          if (txe && rx) begin
            r.rx_take = 1'b1;
            nxt = SND_SEND3;
          end else begin
            nxt = SND_WAIT3;
          end
        end
        SND_SEND3: nxt = SND_READY;
        default:   nxt = SND_BOOT;
      endcase
      sndr_state = nxt;

      // Output action on entry to the new state
      case (nxt)
        SND_INIT: r.setup_strobe = 1'b1;
        SND_SEND1: begin
          popped = '0;
          if (ring_count != 0) begin
            popped = msg_ring[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
          end
          held_low   = popped[15:0];
          r.tx_valid = 1'b1;
          r.tx_byte  = popped[23:16];
        end
        SND_SEND2: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = held_low[15:8];
        end
        SND_SEND3: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = held_low[7:0];
        end
        default: ;
      endcase
    end
    r.sender_state = sndr_state;
    r.queue_count  = ring_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
  endtask

  // Predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    sender_obs_t exp_r;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        exp_r = predict_step(in_bus.kind, in_bus.message, in_bus.rx_has_byte,
                             in_bus.tx_empty);
        pending_obs.push_back(exp_r);
        beats_in++;
        if (exp_r.tx_valid) bytes_sent++;
        if (exp_r.push_dropped) pushes_dropped++;
      end
      if (out_bus.valid && out_bus.ready) begin
        beats_out++;
        if (pending_obs.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          exp_r = pending_obs.pop_front();
          if (out_bus.tx_valid !== exp_r.tx_valid)
            report_mismatch("tx_valid", int'(exp_r.tx_valid), int'(out_bus.tx_valid));
          if (out_bus.tx_byte !== exp_r.tx_byte)
            report_mismatch("tx_byte", int'(exp_r.tx_byte), int'(out_bus.tx_byte));
          if (out_bus.rx_take !== exp_r.rx_take)
            report_mismatch("rx_take", int'(exp_r.rx_take), int'(out_bus.rx_take));
          if (out_bus.setup_strobe !== exp_r.setup_strobe)
            report_mismatch("setup_strobe", int'(exp_r.setup_strobe),
                            int'(out_bus.setup_strobe));
          if (out_bus.sender_state !== exp_r.sender_state)
            report_mismatch("sender_state", int'(exp_r.sender_state),
                            int'(out_bus.sender_state));
          if (out_bus.queue_count !== exp_r.queue_count)
            report_mismatch("queue_count", int'(exp_r.queue_count),
                            int'(out_bus.queue_count));
          if (out_bus.push_dropped !== exp_r.push_dropped)
            report_mismatch("push_dropped", int'(exp_r.push_dropped),
                            int'(out_bus.push_dropped));
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_obs.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready = 1'b0;
      end else if (rx_hold_cycles > 0) begin
        out_bus.ready = 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Offer one input beat and wait until it is taken
  task automatic send_beat(input logic k, input logic [MSG_W-1:0] m,
                           input logic rx, input logic txe);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid       = 1'b1;
    in_bus.kind        = k;
    in_bus.message     = m;
    in_bus.rx_has_byte = rx;
    in_bus.tx_empty    = txe;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  // Serve one queued message with the transmitter always free and requests waiting
  task automatic serve_message();
    repeat (7) send_beat(KIND_TICK, MSG_W'($urandom), 1'b1, 1'b1);
  endtask

  // Boot and init, a push that must not move the sender, ready with no request byte waiting
  task automatic test_boot_sequence();
    send_beat(KIND_TICK, 24'h000000, 1'b1, 1'b1);
    send_beat(KIND_PUSH, 24'h000000, 1'b1, 1'b1);
    send_beat(KIND_TICK, 24'hFFFFFF, 1'b0, 1'b0);
    send_beat(KIND_TICK, 24'hFFFFFF, 1'b0, 1'b1);
  endtask

  // One message through every wait state, with each wait held up before release
  task automatic test_single_message();
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b0);   // ready -> wait1, takes request
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b0);   // transmitter busy
    send_beat(KIND_TICK, 24'h0, 1'b0, 1'b1);   // send high byte
    send_beat(KIND_TICK, 24'h0, 1'b0, 1'b0);   // -> wait2
    send_beat(KIND_TICK, 24'h0, 1'b0, 1'b1);   // no request yet
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b0);   // request but busy
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b1);   // send middle byte
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b1);   // -> wait3
    send_beat(KIND_TICK, 24'h0, 1'b0, 1'b1);
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b1);   // send low byte
    send_beat(KIND_TICK, 24'h0, 1'b1, 1'b1);   // back to ready
  endtask

  // All-ones and mixed message patterns
  task automatic test_message_extremes();
    send_beat(KIND_PUSH, 24'hFFFFFF, 1'b0, 1'b0);
    send_beat(KIND_PUSH, 24'hA55A3C, 1'b1, 1'b0);
    serve_message();
    serve_message();
  endtask

  // Fill the ring and push past full
  task automatic test_full_drop();
    repeat (DEPTH + 3) send_beat(KIND_PUSH, MSG_W'($urandom), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
    serve_message();
    send_beat(KIND_PUSH, 24'h5AA5C3, 1'b0, 1'b0);
    send_beat(KIND_PUSH, 24'h123456, 1'b0, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    int i;
    rx_hold_cycles = 150;
    for (i = 0; i < 30; i++)
      send_beat(1'($urandom_range(0, 1)), MSG_W'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // Random mix in phases of differing push density so the ring fills and drains
  task automatic test_random_mix(input int n_items, input bit gaps);
    int i;
    int push_pct;
    logic [MSG_W-1:0] m;
    logic k;
    idle_en  = gaps;
    push_pct = 30;
    for (i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 5;
          1: push_pct = 25;
          2: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_TICK;
      case ($urandom_range(0, 9))
        0: m = 24'h000000;
        1: m = 24'hFFFFFF;
        default: m = MSG_W'($urandom);
      endcase
      send_beat(k, m, $urandom_range(0, 99) < 60, $urandom_range(0, 99) < 70);
    end
  endtask

  // Predicted state at reset
  task automatic model_reset();
    int i;
    for (i = 0; i < DEPTH; i++) msg_ring[i] = '0;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    held_low   = '0;
    sndr_state = SND_BOOT;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.kind        = KIND_TICK;
    in_bus.message     = '0;
    in_bus.rx_has_byte = 1'b0;
    in_bus.tx_empty    = 1'b0;
    mismatch_count     = 0;
    beats_in           = 0;
    beats_out          = 0;
    bytes_sent         = 0;
    pushes_dropped     = 0;
    idle_cycles        = 0;
    rx_hold_cycles     = 0;
    idle_en            = 1'b0;
    model_reset();

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_boot_sequence();
    test_single_message();
    test_message_extremes();
    idle_en = 1'b1;
    test_full_drop();
    test_backpressure();
    test_random_mix(1100, 1'b1);
    test_random_mix(200, 1'b0);

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_obs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats and %0d result beats: %0d bytes sent, %0d drops.",
             beats_in, beats_out, bytes_sent, pushes_dropped);
    $display("Boot, full ring, long receiver hold-off and random idling were exercised.");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/msf_pkg.sv
hw/rtl/msf_if.sv
hw/rtl/msf_ram.sv
hw/rtl/msf_seq.sv
hw/rtl/uart_message_fifo_byte_sender_core.sv
verif/tb_uart_message_fifo_byte_sender_core.sv
